// ----- sv/psrs_pkg.sv -----
// Package for the packed sorted remainder store.
// Holds the command codes, the transaction structs, the per-cell control struct and defaults.
// No dependencies.
`timescale 1ns / 1ps

package psrs_pkg;

   localparam int SLOT_COUNT_DEFAULT     = 64;
   localparam int REMAINDER_BITS_DEFAULT = 8;
   localparam int WORD_BITS              = 32;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_SPARE  = 2'd3
   } psrs_cmd_type;

   typedef struct packed {
      psrs_cmd_type cmd;
      logic [6:0]   range_first_slot;
      logic [6:0]   range_end_slot;
      logic [7:0]   key_remainder;
   } psrs_req_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] stored_count;
   } psrs_rsp_type;

   typedef struct packed {
      logic load_key;
      logic take_left;
      logic take_right;
   } psrs_cell_ctrl_type;

endpackage

// ----- sv/psrs_cell.sv -----
// One slot cell of the remainder store: holds a remainder, compares it with the key
// and loads the key or takes its neighbour's value on a shift. Depends on psrs_pkg.
`timescale 1ns / 1ps

module psrs_cell import psrs_pkg::*; #(
   parameter int REMAINDER_BITS = REMAINDER_BITS_DEFAULT,
   parameter int IDX_W          = 7,
   parameter int CELL_INDEX     = 0,
   parameter int VALID_BITS     = REMAINDER_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [REMAINDER_BITS-1:0] key,
   input  logic [IDX_W-1:0]          range_first,
   input  logic [IDX_W-1:0]          range_end,
   input  psrs_cell_ctrl_type        ctrl,
   input  logic [REMAINDER_BITS-1:0] left_value,
   input  logic [REMAINDER_BITS-1:0] right_value,
   output logic [REMAINDER_BITS-1:0] value,
   output logic                      ge_flag,
   output logic                      eq_flag
);

   localparam logic [IDX_W-1:0] INDEX = IDX_W'(CELL_INDEX);
   localparam logic [REMAINDER_BITS-1:0] KEEP_MASK =
      {REMAINDER_BITS{1'b1}} << (REMAINDER_BITS - VALID_BITS);

   logic [REMAINDER_BITS-1:0] value_ff;
   logic [REMAINDER_BITS-1:0] value_in;
   logic                      ge_ff;
   logic                      ge_in;
   logic                      eq_ff;
   logic                      eq_in;
   logic                      in_range;

   always_comb begin
      if (ctrl.take_right) begin
         value_in = right_value;
      end else if (ctrl.take_left) begin
         value_in = left_value;
      end else if (ctrl.load_key) begin
         value_in = key;
      end else begin
         value_in = value_ff;
      end
   end

   assign in_range = (INDEX >= range_first) && (INDEX < range_end);
   assign ge_in    = in_range && (value_ff >= key);
   assign eq_in    = in_range && (value_ff == key);

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in & KEEP_MASK;
      end
   end

   always_ff @(posedge clock) begin
      ge_ff <= ge_in;
      eq_ff <= eq_in;
   end

   assign value   = value_ff;
   assign ge_flag = ge_ff;
   assign eq_flag = eq_ff;

endmodule

// ----- sv/psrs_pick.sv -----
// Range-limited priority pick over the cell flags of the remainder store.
// Finds the first slot at or above the key and drives the shift controls of every cell.
// Depends on psrs_pkg.
`timescale 1ns / 1ps

module psrs_pick import psrs_pkg::*; #(
   parameter int CELL_COUNT = 64,
   parameter int IDX_W      = 7
) (
   input  logic [CELL_COUNT-1:0] ge_flags,
   input  logic [CELL_COUNT-1:0] eq_flags,
   input  logic [IDX_W-1:0]      range_max,
   input  psrs_cmd_type          cmd,
   input  logic                  apply,
   output psrs_cell_ctrl_type    ctrl [CELL_COUNT],
   output logic                  eq_found
);

   localparam int LEVELS = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   logic [CELL_COUNT-1:0] prefix [LEVELS+1];
   logic [CELL_COUNT-1:0] sel;
   logic [CELL_COUNT-1:0] after;
   logic                  do_insert;
   logic                  do_remove;

   assign prefix[0] = ge_flags;

   for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
      for (genvar i = 0; i < CELL_COUNT; i++) begin : g_bit
         if (i >= (1 << lv)) begin : g_or
            assign prefix[lv+1][i] = prefix[lv][i] | prefix[lv][i-(1<<lv)];
         end else begin : g_pass
            assign prefix[lv+1][i] = prefix[lv][i];
         end
      end
   end

   assign eq_found  = |(sel & eq_flags);
   assign do_insert = apply && (cmd == CMD_INSERT);
   assign do_remove = apply && (cmd == CMD_REMOVE) && eq_found;

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      localparam logic [IDX_W-1:0] INDEX = IDX_W'(i);
      assign after[i] = prefix[LEVELS][i] || (INDEX >= range_max);
      if (i == 0) begin : g_head
         assign sel[i]            = ge_flags[i];
         assign ctrl[i].load_key  = do_insert && after[i];
         assign ctrl[i].take_left = 1'b0;
      end else begin : g_body
         assign sel[i]            = ge_flags[i] && !prefix[LEVELS][i-1];
         assign ctrl[i].load_key  = do_insert && after[i] && !after[i-1];
         assign ctrl[i].take_left = do_insert && after[i-1];
      end
      assign ctrl[i].take_right = do_remove && after[i];
   end

endmodule

// ----- sv/packed_sorted_remainder_store.sv -----
// Top level of the packed sorted remainder store: request register, sequencer,
// the chain of slot cells and the priority pick. Depends on psrs_pkg, psrs_cell, psrs_pick.
`timescale 1ns / 1ps

// A transaction is taken on the rising edge where start is high and busy is low; its
// payload names a command (lookup, insert, remove), a slot range and a remainder key.
// Every transaction gives exactly one response, shown on rsp_payload for one cycle
// while rsp_strobe is high. The receiver cannot stall, so nothing is held back.
// The store is a row of cells, one per remainder slot plus any slack bits of the last
// word. In the compare state every cell compares its slot with the key and registers the
// result. In the apply state a parallel-prefix priority pick over those flags finds the
// position, and every cell then loads the key or its left or right neighbour at once.
// The response appears on the cycle after that. Busy is high only in the compare cycle,
// so a new transaction may be taken during the shift cycle, before the response to the
// previous one appears.
// A synchronous reset clears every slot and the occupancy count; no clearing pass is
// needed, and a transaction may be started on the first cycle after reset.
module packed_sorted_remainder_store import psrs_pkg::*; #(
   parameter int SLOT_COUNT     = SLOT_COUNT_DEFAULT,
   parameter int REMAINDER_BITS = REMAINDER_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  psrs_req_type req_payload,
   output logic         rsp_strobe,
   output psrs_rsp_type rsp_payload
);

   localparam int TOTAL_BITS =
      ((SLOT_COUNT * REMAINDER_BITS + WORD_BITS - 1) / WORD_BITS) * WORD_BITS;
   localparam int CELL_COUNT = (TOTAL_BITS + REMAINDER_BITS - 1) / REMAINDER_BITS;
   localparam int LAST_BITS  = TOTAL_BITS - (CELL_COUNT - 1) * REMAINDER_BITS;
   localparam int IDX_W      = $clog2(CELL_COUNT + 1);
   localparam int CLAMP_W    = (IDX_W > 7) ? IDX_W : 7;
   localparam int OCC_W      = $clog2(SLOT_COUNT + 1);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COMPARE = 3'b010,
      ST_APPLY   = 3'b100
   } psrs_state_type;

   psrs_state_type state_ff;
   psrs_state_type state_in;

   logic                      accept;
   psrs_cmd_type              cmd_ff;
   logic [REMAINDER_BITS-1:0] key_ff;
   logic [IDX_W-1:0]          first_ff;
   logic [IDX_W-1:0]          end_ff;
   logic [IDX_W-1:0]          max_ff;
   logic [REMAINDER_BITS+7:0] key_wide;
   logic [CLAMP_W-1:0]        first_wide;
   logic [CLAMP_W-1:0]        end_wide;
   logic [IDX_W-1:0]          first_clamped;
   logic [IDX_W-1:0]          end_clamped;

   logic [OCC_W-1:0]          occ_ff;
   logic [OCC_W-1:0]          occ_in;
   logic [OCC_W+6:0]          occ_wide;
   logic                      strobe_ff;
   psrs_rsp_type              rsp_ff;
   psrs_rsp_type              rsp_in;

   logic [REMAINDER_BITS-1:0] cell_value [CELL_COUNT];
   logic [CELL_COUNT-1:0]     ge_flags;
   logic [CELL_COUNT-1:0]     eq_flags;
   psrs_cell_ctrl_type        cell_ctrl [CELL_COUNT];
   logic                      apply;
   logic                      eq_found;

   assign busy   = (state_ff == ST_COMPARE);
   assign accept = start && !busy;
   assign apply  = (state_ff == ST_APPLY);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = start ? ST_COMPARE : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         occ_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= apply;
         occ_ff    <= occ_in;
      end
   end

   assign key_wide   = (REMAINDER_BITS + 8)'(req_payload.key_remainder);
   assign first_wide = CLAMP_W'(req_payload.range_first_slot);
   assign end_wide   = CLAMP_W'(req_payload.range_end_slot);

   always_comb begin
      first_clamped = (first_wide > CLAMP_W'(SLOT_COUNT)) ?
                      IDX_W'(SLOT_COUNT) : first_wide[IDX_W-1:0];
      end_clamped   = (end_wide > CLAMP_W'(SLOT_COUNT)) ?
                      IDX_W'(SLOT_COUNT) : end_wide[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_payload.cmd;
         key_ff   <= key_wide[REMAINDER_BITS-1:0];
         first_ff <= first_clamped;
         end_ff   <= end_clamped;
         max_ff   <= (first_clamped >= end_clamped) ? first_clamped : end_clamped;
      end
   end

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      logic [REMAINDER_BITS-1:0] left_value;
      logic [REMAINDER_BITS-1:0] right_value;
      if (i == 0) begin : g_left_edge
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_value[i-1];
      end
      if (i == CELL_COUNT - 1) begin : g_right_edge
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_value[i+1];
      end

      psrs_cell #(
         .REMAINDER_BITS (REMAINDER_BITS),
         .IDX_W          (IDX_W),
         .CELL_INDEX     (i),
         .VALID_BITS     ((i == CELL_COUNT - 1) ? LAST_BITS : REMAINDER_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .key         (key_ff),
         .range_first (first_ff),
         .range_end   (end_ff),
         .ctrl        (cell_ctrl[i]),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .ge_flag     (ge_flags[i]),
         .eq_flag     (eq_flags[i])
      );
   end

   psrs_pick #(
      .CELL_COUNT (CELL_COUNT),
      .IDX_W      (IDX_W)
   ) u_pick (
      .ge_flags  (ge_flags),
      .eq_flags  (eq_flags),
      .range_max (max_ff),
      .cmd       (cmd_ff),
      .apply     (apply),
      .ctrl      (cell_ctrl),
      .eq_found  (eq_found)
   );

   always_comb begin
      occ_in = occ_ff;
      if (apply) begin
         case (cmd_ff)
            CMD_INSERT: begin
               if (occ_ff < OCC_W'(SLOT_COUNT)) occ_in = occ_ff + OCC_W'(1);
            end
            CMD_REMOVE: begin
               if (eq_found && (occ_ff != '0)) occ_in = occ_ff - OCC_W'(1);
            end
            default: begin
               occ_in = occ_ff;
            end
         endcase
      end
   end

   assign occ_wide            = (OCC_W + 7)'(occ_in);
   assign rsp_in.hit          = eq_found && (cmd_ff != CMD_INSERT);
   assign rsp_in.stored_count = occ_wide[6:0];

   always_ff @(posedge clock) begin
      if (apply) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for packed_sorted_remainder_store: directed and random lookup,
// insert, remove and spare transactions, checked against a slot-array predictor.
// Depends on psrs_pkg and the packed_sorted_remainder_store RTL.
`timescale 1ns / 1ps

module tb_top;
   import psrs_pkg::*;

   localparam int SLOTS         = SLOT_COUNT_DEFAULT;
   localparam int IDLE_LIMIT    = 1000;
   localparam int TAIL_CYCLES   = 8;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 125;

   typedef struct {
      psrs_req_type req;
      bit           drain_first;
   } queued_command_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   psrs_req_type req_payload = '0;
   logic         rsp_strobe;
   psrs_rsp_type rsp_payload;

   queued_command_type command_queue[$];
   psrs_rsp_type       awaited_replies[$];

   logic [7:0] shadow_slots[SLOTS];
   int         shadow_fill;

   int mismatch_count = 0;
   int idle_cycles    = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   int insert_total   = 0;
   int lookup_total   = 0;
   int remove_total   = 0;
   int spare_total    = 0;
   int hit_total      = 0;
   int full_inserts   = 0;
   int peak_fill      = 0;
   int reply_total    = 0;

   packed_sorted_remainder_store uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic psrs_rsp_type apply_command(psrs_req_type rq);
      int         first_slot;
      int         end_slot;
      int         pos_slot;
      int         s;
      bit         found;
      bit         equal;
      logic [7:0] key;
      psrs_rsp_type reply;
      first_slot = (rq.range_first_slot > SLOTS) ? SLOTS : int'(rq.range_first_slot);
      end_slot   = (rq.range_end_slot > SLOTS) ? SLOTS : int'(rq.range_end_slot);
      key        = rq.key_remainder;
      equal      = 1'b0;
      found      = 1'b0;
      pos_slot   = first_slot;
      if (first_slot < end_slot) begin
         pos_slot = end_slot;
         for (s = first_slot; s < end_slot && !found; s++) begin
            if (key <= shadow_slots[s]) begin
               found    = 1'b1;
               pos_slot = s;
               equal    = (key == shadow_slots[s]);
            end
         end
      end
      reply.hit = 1'b0;
      case (rq.cmd)
         CMD_INSERT: begin
            if (shadow_fill == SLOTS) full_inserts++;
            for (s = SLOTS - 1; s > pos_slot; s--) shadow_slots[s] = shadow_slots[s - 1];
            if (pos_slot < SLOTS) shadow_slots[pos_slot] = key;
            if (shadow_fill < SLOTS) shadow_fill++;
         end
         CMD_REMOVE: begin
            if (equal) begin
               for (s = pos_slot; s < SLOTS - 1; s++) shadow_slots[s] = shadow_slots[s + 1];
               shadow_slots[SLOTS - 1] = '0;
               if (shadow_fill > 0) shadow_fill--;
               reply.hit = 1'b1;
            end
         end
         default: begin
            reply.hit = equal;
         end
      endcase
      reply.stored_count = shadow_fill[6:0];
      return reply;
   endfunction

   function automatic psrs_req_type make_request(psrs_cmd_type cmd, int first_slot,
                                                 int end_slot, int key);
      psrs_req_type rq;
      rq.cmd              = cmd;
      rq.range_first_slot = first_slot[6:0];
      rq.range_end_slot   = end_slot[6:0];
      rq.key_remainder    = key[7:0];
      return rq;
   endfunction

   function automatic psrs_req_type random_request(int insert_weight);
      int           pick;
      int           first_slot;
      int           end_slot;
      int           key;
      psrs_cmd_type cmd;
      pick = $urandom_range(0, 99);
      if (pick < insert_weight) cmd = CMD_INSERT;
      else if (pick < insert_weight + (100 - insert_weight) / 2) cmd = CMD_REMOVE;
      else if (pick < 97) cmd = CMD_LOOKUP;
      else cmd = CMD_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         first_slot = $urandom_range(0, SLOTS - 1);
         end_slot   = first_slot + $urandom_range(0, 12);
      end else if (pick < 90) begin
         first_slot = 0;
         end_slot   = SLOTS;
      end else begin
         first_slot = $urandom_range(0, 127);
         end_slot   = $urandom_range(0, 127);
      end
      if ($urandom_range(0, 1) == 0) key = $urandom_range(0, 255);
      else key = $urandom_range(0, 7) * 36;
      return make_request(cmd, first_slot, end_slot, key);
   endfunction

   task automatic queue_command(psrs_req_type rq, bit drain_first);
      queued_command_type item;
      item.req         = rq;
      item.drain_first = drain_first;
      command_queue.push_back(item);
   endtask

   always @(posedge clock) begin
      bit                 taken;
      queued_command_type item;
      if (reset) begin
         start       <= 1'b0;
         req_payload <= '0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            awaited_replies.push_back(apply_command(req_payload));
            case (req_payload.cmd)
               CMD_INSERT: insert_total++;
               CMD_LOOKUP: lookup_total++;
               CMD_REMOVE: remove_total++;
               default:    spare_total++;
            endcase
            if (shadow_fill > peak_fill) peak_fill = shadow_fill;
         end
         if (!start || taken) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (command_queue.size() == 0) begin
               start <= 1'b0;
            end else if (command_queue[0].drain_first && awaited_replies.size() != 0) begin
               start <= 1'b0;
            end else begin
               item = command_queue.pop_front();
               start       <= 1'b1;
               req_payload <= item.req;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 1) ? $urandom_range(1, 8)
                                                    : $urandom_range(20, 60);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      psrs_rsp_type want;
      if (!reset && rsp_strobe) begin
         reply_total++;
         if (awaited_replies.size() == 0) begin
            $error("unexpected reply: hit %0d, stored_count %0d",
                   rsp_payload.hit, rsp_payload.stored_count);
            mismatch_count++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_payload.hit) hit_total++;
            if (rsp_payload.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_payload.hit);
               mismatch_count++;
            end
            if (rsp_payload.stored_count !== want.stored_count) begin
               $error("stored_count: expected %0d, got %0d",
                      want.stored_count, rsp_payload.stored_count);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      int phase;
      int n;
      for (n = 0; n < SLOTS; n++) shadow_slots[n] = '0;
      shadow_fill = 0;

      queue_command(make_request(CMD_LOOKUP, 0, 64, 0), 1'b0);
      queue_command(make_request(CMD_REMOVE, 0, 1, 0), 1'b0);
      queue_command(make_request(CMD_INSERT, 0, 64, 255), 1'b0);
      queue_command(make_request(CMD_INSERT, 100, 127, 128), 1'b0);
      queue_command(make_request(CMD_INSERT, 10, 3, 90), 1'b0);
      queue_command(make_request(CMD_LOOKUP, 10, 11, 90), 1'b0);
      queue_command(make_request(CMD_LOOKUP, 5, 5, 90), 1'b0);
      queue_command(make_request(CMD_SPARE, 0, 64, 90), 1'b0);
      queue_command(make_request(CMD_INSERT, 0, 0, 1), 1'b0);
      queue_command(make_request(CMD_INSERT, 63, 64, 119), 1'b0);
      queue_command(make_request(CMD_LOOKUP, 63, 64, 119), 1'b0);
      queue_command(make_request(CMD_INSERT, 127, 127, 170), 1'b0);
      queue_command(make_request(CMD_REMOVE, 0, 64, 90), 1'b0);
      queue_command(make_request(CMD_REMOVE, 20, 10, 0), 1'b0);
      queue_command(make_request(CMD_REMOVE, 64, 64, 0), 1'b0);
      queue_command(make_request(CMD_LOOKUP, 0, 127, 255), 1'b0);
      queue_command(make_request(CMD_INSERT, 0, 64, 0), 1'b0);
      queue_command(make_request(CMD_REMOVE, 0, 64, 1), 1'b0);
      queue_command(make_request(CMD_LOOKUP, 85, 42, 85), 1'b0);

      for (phase = 0; phase < PHASES; phase++) begin
         for (n = 0; n < PHASE_ITEMS; n++) begin
            queue_command(random_request((phase % 2 == 0) ? 80 : 15), n == 0);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (!(command_queue.size() == 0 && !start && awaited_replies.size() == 0)
             && idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      if (idle_cycles < IDLE_LIMIT) repeat (TAIL_CYCLES) @(posedge clock);

      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
      end else begin
         if (awaited_replies.size() != 0) begin
            $error("%0d replies never arrived", awaited_replies.size());
            mismatch_count++;
         end
         $display("Ran %0d inserts, %0d lookups, %0d removes and %0d spare commands; %0d replies.",
                  insert_total, lookup_total, remove_total, spare_total, reply_total);
         $display("Replies with hit set: %0d; peak fill %0d; inserts into a full store: %0d.",
                  hit_total, peak_fill, full_inserts);
         if (mismatch_count == 0) begin
            $display("Simulation PASSED");
         end else begin
            $display("Simulation FAILED");
         end
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/psrs_pkg.sv
sv/psrs_cell.sv
sv/psrs_pick.sv
sv/packed_sorted_remainder_store.sv
test/tb_top.sv
